// ===== sv/dmwbc_pkg.sv =====
// ----------------------------------------------------------------------------
// dmwbc_pkg
// Shared types and constants of the direct-mapped write-back cache model.
// ----------------------------------------------------------------------------
package dmwbc_pkg;

    localparam int ADDR_FIELD_BITS = 32;
    localparam int ADDR_WIDE_BITS  = 64;
    localparam int OFFSET_BITS     = 4;
    localparam int PENALTY_BITS    = 8;
    localparam int CYCLES_BITS     = 9;
    localparam int BYTES_BITS      = 5;
    localparam int ACCESS_CNT_BITS = 32;
    localparam int MISS_CNT_BITS   = 32;
    localparam int CYCLE_SUM_BITS  = 48;

    localparam logic [PENALTY_BITS-1:0] PENALTY_RESET = 8'd80;
    localparam logic [BYTES_BITS-1:0]   BLOCK_BYTES   = 5'd16;
    localparam logic [CYCLES_BITS-1:0]  HIT_CYCLES    = 9'd1;

    typedef enum logic [1:0] {
        OUTCOME_HIT        = 2'd0,
        OUTCOME_CLEAN_MISS = 2'd1,
        OUTCOME_DIRTY_MISS = 2'd2
    } outcome_t;

    typedef struct packed {
        logic clear_en;
        logic capture_en;
        logic resolve_en;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clear_last;
    } ctrl_status_t;

endpackage

// ===== sv/dmwbc_if.sv =====
// ----------------------------------------------------------------------------
// dmwbc_if
// Request and response channels of the cache, valid/ready per beat.
// ----------------------------------------------------------------------------
interface dmwbc_req_if;

    logic        valid;
    logic        ready;
    logic        kind;
    logic [31:0] address;

    modport source (output valid, output kind, output address, input ready);
    modport sink   (input valid, input kind, input address, output ready);

endinterface

interface dmwbc_resp_if #(
    parameter int INDEX_BITS = 6,
    parameter int TAG_BITS   = 22
);

    logic                  valid;
    logic                  ready;
    logic [1:0]            outcome;
    logic [INDEX_BITS-1:0] line_index;
    logic [TAG_BITS-1:0]   new_tag;
    logic                  old_valid;
    logic [TAG_BITS-1:0]   old_tag;
    logic                  old_dirty;
    logic [8:0]            access_cycles;
    logic [4:0]            bytes_fetched;
    logic [4:0]            bytes_written_back;
    logic [31:0]           total_accesses;
    logic [31:0]           total_misses;
    logic [47:0]           total_cycles;

    modport source (
        output valid, output outcome, output line_index, output new_tag,
        output old_valid, output old_tag, output old_dirty, output access_cycles,
        output bytes_fetched, output bytes_written_back, output total_accesses,
        output total_misses, output total_cycles, input ready
    );
    modport sink (
        input valid, input outcome, input line_index, input new_tag,
        input old_valid, input old_tag, input old_dirty, input access_cycles,
        input bytes_fetched, input bytes_written_back, input total_accesses,
        input total_misses, input total_cycles, output ready
    );

endinterface

// ===== sv/dmwbc_ctrl.sv =====
// ----------------------------------------------------------------------------
// dmwbc_ctrl
// Sequencer: tag RAM clearing pass, lookup, resolve and output handshake.
// ----------------------------------------------------------------------------
module dmwbc_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    output logic                    out_valid,
    input  logic                    out_ready,
    output dmwbc_pkg::ctrl_cmd_t    cmd,
    input  dmwbc_pkg::ctrl_status_t status
);
    import dmwbc_pkg::*;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RESOLVE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   load;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign load      = (state_reg == ST_RESOLVE) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_en = 1'b1;
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture_en = 1'b1;
                    state_next     = ST_RESOLVE;
                end
            end
            ST_RESOLVE:
            begin
                if (load)
                begin
                    cmd.resolve_en = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== sv/dmwbc_datapath.sv =====
// ----------------------------------------------------------------------------
// dmwbc_datapath
// Tag RAM, hit/miss resolve, cycle charge, saturating totals, result register.
// ----------------------------------------------------------------------------
module dmwbc_datapath #(
    parameter int INDEX_BITS   = 6,
    parameter int ADDRESS_BITS = 32,
    parameter int TAG_BITS     = ADDRESS_BITS - dmwbc_pkg::OFFSET_BITS - INDEX_BITS
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  dmwbc_pkg::ctrl_cmd_t                    cmd,
    output dmwbc_pkg::ctrl_status_t                 status,
    input  logic                                    cfg_wr_en,
    input  logic [dmwbc_pkg::PENALTY_BITS-1:0]      cfg_wr_data,
    input  logic                                    kind,
    input  logic [dmwbc_pkg::ADDR_FIELD_BITS-1:0]   address,
    output logic [1:0]                              outcome,
    output logic [INDEX_BITS-1:0]                   line_index,
    output logic [TAG_BITS-1:0]                     new_tag,
    output logic                                    old_valid,
    output logic [TAG_BITS-1:0]                     old_tag,
    output logic                                    old_dirty,
    output logic [dmwbc_pkg::CYCLES_BITS-1:0]       access_cycles,
    output logic [dmwbc_pkg::BYTES_BITS-1:0]        bytes_fetched,
    output logic [dmwbc_pkg::BYTES_BITS-1:0]        bytes_written_back,
    output logic [dmwbc_pkg::ACCESS_CNT_BITS-1:0]   total_accesses,
    output logic [dmwbc_pkg::MISS_CNT_BITS-1:0]     total_misses,
    output logic [dmwbc_pkg::CYCLE_SUM_BITS-1:0]    total_cycles
);
    import dmwbc_pkg::*;

    localparam int LINES     = 1 << INDEX_BITS;
    localparam int LINE_BITS = TAG_BITS + 2;
    localparam int VALID_BIT = TAG_BITS + 1;
    localparam int DIRTY_BIT = TAG_BITS;

    logic [LINE_BITS-1:0]       line_mem [LINES];
    logic [LINE_BITS-1:0]       line_rd_reg;
    logic [LINE_BITS-1:0]       line_wr;
    logic [INDEX_BITS-1:0]      clr_idx_reg;

    logic [ADDR_WIDE_BITS-1:0]  addr_wide;
    logic [ADDRESS_BITS-1:0]    addr_m;
    logic [INDEX_BITS-1:0]      req_idx;
    logic [TAG_BITS-1:0]        req_tag;

    logic                       kind_reg;
    logic [INDEX_BITS-1:0]      idx_reg;
    logic [TAG_BITS-1:0]        tag_reg;

    logic [PENALTY_BITS-1:0]    penalty_reg;
    logic [ACCESS_CNT_BITS-1:0] acc_cnt_reg;
    logic [ACCESS_CNT_BITS-1:0] acc_cnt_next;
    logic [MISS_CNT_BITS-1:0]   miss_cnt_reg;
    logic [MISS_CNT_BITS-1:0]   miss_cnt_next;
    logic [CYCLE_SUM_BITS-1:0]  cyc_sum_reg;
    logic [CYCLE_SUM_BITS-1:0]  cyc_sum_next;
    logic [CYCLE_SUM_BITS:0]    cyc_sum_wide;

    logic                       rd_valid;
    logic                       rd_dirty;
    logic [TAG_BITS-1:0]        rd_tag;
    logic                       hit;
    logic                       dirty_miss;
    outcome_t                   res_outcome;
    logic [CYCLES_BITS-1:0]     res_cycles;

    outcome_t                   outcome_reg;
    logic [INDEX_BITS-1:0]      line_index_reg;
    logic [TAG_BITS-1:0]        new_tag_reg;
    logic                       old_valid_reg;
    logic [TAG_BITS-1:0]        old_tag_reg;
    logic                       old_dirty_reg;
    logic [CYCLES_BITS-1:0]     cycles_reg;

    assign addr_wide = {{(ADDR_WIDE_BITS-ADDR_FIELD_BITS){1'b0}}, address};
    assign addr_m    = addr_wide[ADDRESS_BITS-1:0];
    assign req_idx   = addr_m[OFFSET_BITS +: INDEX_BITS];
    assign req_tag   = addr_m[ADDRESS_BITS-1:OFFSET_BITS+INDEX_BITS];

    assign status.clear_last = (clr_idx_reg == {INDEX_BITS{1'b1}});

    assign rd_valid   = line_rd_reg[VALID_BIT];
    assign rd_dirty   = line_rd_reg[DIRTY_BIT];
    assign rd_tag     = line_rd_reg[TAG_BITS-1:0];
    assign hit        = rd_valid && (rd_tag == tag_reg);
    assign dirty_miss = !hit && rd_valid && rd_dirty;

    always_comb
    begin
        if (hit)
        begin
            res_outcome = OUTCOME_HIT;
            res_cycles  = HIT_CYCLES;
        end
        else if (dirty_miss)
        begin
            res_outcome = OUTCOME_DIRTY_MISS;
            res_cycles  = {penalty_reg, 1'b1};
        end
        else
        begin
            res_outcome = OUTCOME_CLEAN_MISS;
            res_cycles  = {1'b0, penalty_reg} + HIT_CYCLES;
        end
    end

    assign line_wr = {1'b1, (hit ? (rd_dirty | kind_reg) : kind_reg), tag_reg};

    assign acc_cnt_next  = (&acc_cnt_reg) ? acc_cnt_reg : acc_cnt_reg + 1'b1;
    assign miss_cnt_next = (hit || (&miss_cnt_reg)) ? miss_cnt_reg : miss_cnt_reg + 1'b1;
    assign cyc_sum_wide  = {1'b0, cyc_sum_reg}
                         + {{(CYCLE_SUM_BITS+1-CYCLES_BITS){1'b0}}, res_cycles};
    assign cyc_sum_next  = cyc_sum_wide[CYCLE_SUM_BITS] ? {CYCLE_SUM_BITS{1'b1}}
                                                        : cyc_sum_wide[CYCLE_SUM_BITS-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.clear_en)
        begin
            line_mem[clr_idx_reg] <= '0;
        end
        else if (cmd.resolve_en)
        begin
            line_mem[idx_reg] <= line_wr;
        end
        if (cmd.capture_en)
        begin
            line_rd_reg <= line_mem[req_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture_en)
        begin
            kind_reg <= kind;
            idx_reg  <= req_idx;
            tag_reg  <= req_tag;
        end
        if (cmd.resolve_en)
        begin
            outcome_reg    <= res_outcome;
            line_index_reg <= idx_reg;
            new_tag_reg    <= tag_reg;
            old_valid_reg  <= rd_valid;
            old_tag_reg    <= rd_tag;
            old_dirty_reg  <= rd_dirty;
            cycles_reg     <= res_cycles;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_idx_reg  <= '0;
            penalty_reg  <= PENALTY_RESET;
            acc_cnt_reg  <= '0;
            miss_cnt_reg <= '0;
            cyc_sum_reg  <= '0;
        end
        else
        begin
            if (cmd.clear_en)
            begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
            end
            if (cfg_wr_en)
            begin
                penalty_reg <= cfg_wr_data;
            end
            if (cmd.resolve_en)
            begin
                acc_cnt_reg  <= acc_cnt_next;
                miss_cnt_reg <= miss_cnt_next;
                cyc_sum_reg  <= cyc_sum_next;
            end
        end
    end

    assign outcome            = outcome_reg;
    assign line_index         = line_index_reg;
    assign new_tag            = new_tag_reg;
    assign old_valid          = old_valid_reg;
    assign old_tag            = old_tag_reg;
    assign old_dirty          = old_dirty_reg;
    assign access_cycles      = cycles_reg;
    assign bytes_fetched      = (outcome_reg == OUTCOME_HIT) ? '0 : BLOCK_BYTES;
    assign bytes_written_back = (outcome_reg == OUTCOME_DIRTY_MISS) ? BLOCK_BYTES : '0;
    assign total_accesses     = acc_cnt_reg;
    assign total_misses       = miss_cnt_reg;
    assign total_cycles       = cyc_sum_reg;

endmodule

// ===== sv/direct_mapped_writeback_cache.sv =====
// A request beat is accepted and its line is read from the tag RAM in that cycle;
// the result beat becomes valid when the access resolves, which waits while the
// previous result beat is still unaccepted. A new request is accepted only after
// the previous access has read and then written back its line in the single-ported tag RAM.
// Reset: counters clear and miss_penalty returns to 80; the tag RAM is then cleared
// one line per cycle over all 2**INDEX_BITS lines, with no request accepted meanwhile.
// ----------------------------------------------------------------------------
// direct_mapped_writeback_cache
// Direct-mapped write-back cache tag model with cycle and traffic accounting.
// ----------------------------------------------------------------------------
module direct_mapped_writeback_cache #(
    parameter int INDEX_BITS   = 6,
    parameter int ADDRESS_BITS = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [dmwbc_pkg::PENALTY_BITS-1:0] cfg_wr_data,
    dmwbc_req_if.sink                          req,
    dmwbc_resp_if.source                       resp
);
    import dmwbc_pkg::*;

    localparam int TAG_BITS = ADDRESS_BITS - OFFSET_BITS - INDEX_BITS;

    ctrl_cmd_t    cmd;
    ctrl_status_t status;

    dmwbc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (resp.valid),
        .out_ready (resp.ready),
        .cmd       (cmd),
        .status    (status)
    );

    dmwbc_datapath #(
        .INDEX_BITS   (INDEX_BITS),
        .ADDRESS_BITS (ADDRESS_BITS),
        .TAG_BITS     (TAG_BITS)
    ) u_datapath (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .status             (status),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_wr_data        (cfg_wr_data),
        .kind               (req.kind),
        .address            (req.address),
        .outcome            (resp.outcome),
        .line_index         (resp.line_index),
        .new_tag            (resp.new_tag),
        .old_valid          (resp.old_valid),
        .old_tag            (resp.old_tag),
        .old_dirty          (resp.old_dirty),
        .access_cycles      (resp.access_cycles),
        .bytes_fetched      (resp.bytes_fetched),
        .bytes_written_back (resp.bytes_written_back),
        .total_accesses     (resp.total_accesses),
        .total_misses       (resp.total_misses),
        .total_cycles       (resp.total_cycles)
    );

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the direct-mapped write-back cache. A shadow copy of
// the tag store, line flags, miss penalty and running totals predicts every
// response beat. Directed accesses cover hits, clean and dirty misses and the
// address extremes; random accesses are biased toward line conflicts across
// several miss penalties and handshake stall patterns.
// ----------------------------------------------------------------------------
module tb;

    import dmwbc_pkg::*;

    localparam int LINE_BITS        = 6;
    localparam int TAG_W            = ADDR_FIELD_BITS - OFFSET_BITS - LINE_BITS;
    localparam int NUM_LINES        = 1 << LINE_BITS;
    localparam int RANDOM_PHASES    = 6;
    localparam int ACCESSES_PER_RUN = 290;
    localparam int STALL_LIMIT      = 4000;
    localparam logic [CYCLE_SUM_BITS-1:0] CYCLE_SUM_MAX = {CYCLE_SUM_BITS{1'b1}};

    typedef enum logic {
        ACC_READ  = 1'b0,
        ACC_WRITE = 1'b1
    } access_kind_t;

    typedef struct {
        access_kind_t kind;
        logic [31:0]  address;
    } access_t;

    typedef struct {
        outcome_t                   outcome;
        logic [LINE_BITS-1:0]       line_index;
        logic [TAG_W-1:0]           new_tag;
        logic                       old_valid;
        logic [TAG_W-1:0]           old_tag;
        logic                       old_dirty;
        logic [CYCLES_BITS-1:0]     access_cycles;
        logic [BYTES_BITS-1:0]      bytes_fetched;
        logic [BYTES_BITS-1:0]      bytes_written_back;
        logic [ACCESS_CNT_BITS-1:0] total_accesses;
        logic [MISS_CNT_BITS-1:0]   total_misses;
        logic [CYCLE_SUM_BITS-1:0]  total_cycles;
    } lookup_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [PENALTY_BITS-1:0] cfg_wr_data = '0;
    logic req_valid = 1'b0;
    logic req_kind = 1'b0;
    logic [31:0] req_address = '0;
    logic resp_ready = 1'b0;

    dmwbc_req_if req_bus ();
    dmwbc_resp_if #(.INDEX_BITS(LINE_BITS), .TAG_BITS(TAG_W)) resp_bus ();

    assign req_bus.valid   = req_valid;
    assign req_bus.kind    = req_kind;
    assign req_bus.address = req_address;
    assign resp_bus.ready  = resp_ready;

    direct_mapped_writeback_cache u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (req_bus),
        .resp        (resp_bus)
    );

    access_t        pending_accesses [$];
    lookup_result_t expected_lookups [$];
    logic [31:0]    recent_addresses [$];

    logic [TAG_W-1:0]           shadow_tag   [NUM_LINES];
    logic                       shadow_valid [NUM_LINES];
    logic                       shadow_dirty [NUM_LINES];
    logic [PENALTY_BITS-1:0]    shadow_penalty;
    logic [ACCESS_CNT_BITS-1:0] shadow_accesses;
    logic [MISS_CNT_BITS-1:0]   shadow_misses;
    logic [CYCLE_SUM_BITS-1:0]  shadow_cycles;

    int send_idle_pct = 17;
    int recv_idle_pct = 83;
    int error_count = 0;
    int checked_count = 0;
    int hit_count = 0;
    int clean_miss_count = 0;
    int dirty_miss_count = 0;
    int penalty_writes = 0;
    int stall_cycles = 0;

    always #6 clk = ~clk;

    function automatic lookup_result_t predict_lookup(access_kind_t kind,
                                                      logic [31:0] address);
        lookup_result_t r;
        logic [LINE_BITS-1:0] line_sel;
        logic [TAG_W-1:0] tag;
        line_sel = address[OFFSET_BITS +: LINE_BITS];
        tag = address[31 -: TAG_W];
        r.line_index = line_sel;
        r.new_tag = tag;
        r.old_valid = shadow_valid[line_sel];
        r.old_tag = shadow_tag[line_sel];
        r.old_dirty = shadow_dirty[line_sel];
        r.bytes_fetched = '0;
        r.bytes_written_back = '0;
        if (r.old_valid && r.old_tag == tag) begin
            r.outcome = OUTCOME_HIT;
            r.access_cycles = HIT_CYCLES;
            if (kind == ACC_WRITE)
                shadow_dirty[line_sel] = 1'b1;
        end
        else begin
            if (r.old_valid && r.old_dirty) begin
                r.outcome = OUTCOME_DIRTY_MISS;
                r.access_cycles = {shadow_penalty, 1'b1};
                r.bytes_written_back = BLOCK_BYTES;
            end
            else begin
                r.outcome = OUTCOME_CLEAN_MISS;
                r.access_cycles = {1'b0, shadow_penalty} + 9'd1;
            end
            r.bytes_fetched = BLOCK_BYTES;
            shadow_tag[line_sel] = tag;
            shadow_valid[line_sel] = 1'b1;
            shadow_dirty[line_sel] = (kind == ACC_WRITE);
            if (shadow_misses != '1)
                shadow_misses = shadow_misses + 1'b1;
        end
        if (shadow_accesses != '1)
            shadow_accesses = shadow_accesses + 1'b1;
        if (shadow_cycles > CYCLE_SUM_MAX - CYCLE_SUM_BITS'(r.access_cycles))
            shadow_cycles = CYCLE_SUM_MAX;
        else
            shadow_cycles = shadow_cycles + CYCLE_SUM_BITS'(r.access_cycles);
        r.total_accesses = shadow_accesses;
        r.total_misses = shadow_misses;
        r.total_cycles = shadow_cycles;
        return r;
    endfunction

    function automatic void check_field(string name, logic [47:0] want, logic [47:0] got);
        if (got !== want) begin
            error_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endfunction

    function automatic void queue_access(access_kind_t kind, logic [31:0] address);
        access_t a;
        a.kind = kind;
        a.address = address;
        pending_accesses.insert(pending_accesses.size(), a);
    endfunction

    // bias toward a handful of tags per line so hits and dirty evictions are common
    function automatic access_t random_access();
        access_t a;
        int pick;
        logic [TAG_W-1:0] tag;
        pick = $urandom_range(99, 0);
        a.kind = access_kind_t'($urandom_range(1, 0));
        if (pick < 40) begin
            a.address = {TAG_W'($urandom_range(3, 0)), LINE_BITS'($urandom_range(15, 0)),
                         4'($urandom_range(15, 0))};
        end
        else if (pick < 65 && recent_addresses.size() > 0) begin
            a.address = recent_addresses[$urandom_range(recent_addresses.size() - 1, 0)];
            a.address[3:0] = 4'($urandom_range(15, 0));
        end
        else if (pick < 80) begin
            case ($urandom_range(2, 0))
                0: tag = '0;
                1: tag = '1;
                default: tag = TAG_W'($urandom);
            endcase
            a.address = {tag, LINE_BITS'($urandom), 4'($urandom)};
        end
        else begin
            a.address = $urandom;
        end
        recent_addresses.insert(recent_addresses.size(), a.address);
        if (recent_addresses.size() > 8)
            void'(recent_addresses.pop_front());
        return a;
    endfunction

    task automatic wait_idle();
        while (pending_accesses.size() != 0 || req_valid || expected_lookups.size() != 0)
            @(negedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_penalty(logic [PENALTY_BITS-1:0] value);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        repeat (2) @(posedge clk);
        penalty_writes++;
    endtask

    always @(posedge clk) begin
        access_t a;
        if (rst_n) begin
            if (!req_valid || req_bus.ready === 1'b1) begin
                if (pending_accesses.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
                    a = pending_accesses.pop_front();
                    req_valid <= 1'b1;
                    req_kind <= a.kind;
                    req_address <= a.address;
                end
                else begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n)
            resp_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
    end

    always @(posedge clk) begin
        lookup_result_t want;
        if (!rst_n) begin
            for (int i = 0; i < NUM_LINES; i++) begin
                shadow_tag[i] = '0;
                shadow_valid[i] = 1'b0;
                shadow_dirty[i] = 1'b0;
            end
            shadow_penalty = PENALTY_RESET;
            shadow_accesses = '0;
            shadow_misses = '0;
            shadow_cycles = '0;
        end
        else begin
            if (cfg_wr_en)
                shadow_penalty = cfg_wr_data;
            if (req_valid && req_bus.ready === 1'b1)
                expected_lookups.insert(expected_lookups.size(),
                                        predict_lookup(access_kind_t'(req_kind), req_address));
            if (resp_bus.valid === 1'b1 && resp_ready) begin
                if (expected_lookups.size() == 0) begin
                    error_count++;
                    $display("%0t: response beat with no access outstanding", $time);
                end
                else begin
                    want = expected_lookups.pop_front();
                    checked_count++;
                    case (want.outcome)
                        OUTCOME_HIT:        hit_count++;
                        OUTCOME_CLEAN_MISS: clean_miss_count++;
                        default:            dirty_miss_count++;
                    endcase
                    check_field("outcome", 48'(want.outcome), 48'(resp_bus.outcome));
                    check_field("line_index", 48'(want.line_index), 48'(resp_bus.line_index));
                    check_field("new_tag", 48'(want.new_tag), 48'(resp_bus.new_tag));
                    check_field("old_valid", 48'(want.old_valid), 48'(resp_bus.old_valid));
                    check_field("old_tag", 48'(want.old_tag), 48'(resp_bus.old_tag));
                    check_field("old_dirty", 48'(want.old_dirty), 48'(resp_bus.old_dirty));
                    check_field("access_cycles", 48'(want.access_cycles),
                                48'(resp_bus.access_cycles));
                    check_field("bytes_fetched", 48'(want.bytes_fetched),
                                48'(resp_bus.bytes_fetched));
                    check_field("bytes_written_back", 48'(want.bytes_written_back),
                                48'(resp_bus.bytes_written_back));
                    check_field("total_accesses", 48'(want.total_accesses),
                                48'(resp_bus.total_accesses));
                    check_field("total_misses", 48'(want.total_misses),
                                48'(resp_bus.total_misses));
                    check_field("total_cycles", want.total_cycles, resp_bus.total_cycles);
                end
            end
        end
    end

    always @(posedge clk) begin
        if ((req_valid && req_bus.ready === 1'b1) || (resp_bus.valid === 1'b1 && resp_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        logic [PENALTY_BITS-1:0] penalty;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // line 0: cold miss on tag 0, hits, write hit, dirty eviction by a read
        queue_access(ACC_READ,  32'h0000_0000);
        queue_access(ACC_READ,  32'h0000_000F);
        queue_access(ACC_WRITE, 32'h0000_0004);
        queue_access(ACC_READ,  32'h0000_0008);
        queue_access(ACC_READ,  32'h0000_0400);
        queue_access(ACC_READ,  32'h0000_0000);
        // line 63 with the top tag, then evicted by tag 0
        queue_access(ACC_WRITE, 32'hFFFF_FFFF);
        queue_access(ACC_WRITE, 32'hFFFF_FFF0);
        queue_access(ACC_READ,  32'h0000_03F0);
        queue_access(ACC_WRITE, 32'h0000_03F0);
        queue_access(ACC_READ,  32'hFFFF_FFF8);
        // write misses on clean and dirty lines
        queue_access(ACC_WRITE, 32'hFFFF_FC00);
        queue_access(ACC_WRITE, 32'h0000_0000);
        queue_access(ACC_READ,  32'h0000_0000);
        queue_access(ACC_WRITE, 32'h0000_0010);
        queue_access(ACC_READ,  32'h0000_0010);
        queue_access(ACC_READ,  32'hAAAA_AAAA);
        queue_access(ACC_WRITE, 32'h5555_5555);
        queue_access(ACC_WRITE, 32'hAAAA_AAAA);
        queue_access(ACC_READ,  32'h5555_5555);
        wait_idle();

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase / 2)
                0: begin send_idle_pct = 17; recv_idle_pct = 83; end
                1: begin send_idle_pct = 83; recv_idle_pct = 17; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            case (phase)
                0: penalty = '0;
                1: penalty = '1;
                3: penalty = 8'd1;
                4: penalty = 8'd254;
                default: penalty = PENALTY_BITS'($urandom_range(255, 0));
            endcase
            write_penalty(penalty);
            repeat (ACCESSES_PER_RUN)
                pending_accesses.insert(pending_accesses.size(), random_access());
            wait_idle();
        end

        repeat (6) @(posedge clk);
        $display("tb: checked %0d accesses: %0d hits, %0d clean misses, %0d dirty misses",
                 checked_count, hit_count, clean_miss_count, dirty_miss_count);
        $display("tb: reset penalty plus %0d penalty writes, three stall patterns, %0d errors",
                 penalty_writes, error_count);
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
